### src/dtgp_pkg.sv
// ============================================================================
// dtgp_pkg: shared constants and types for the disparity-to-point pipeline
// Field widths, table slot map, register indexes and derived datapath widths.
// ============================================================================
package dtgp_pkg;

    // Pixel coordinate width and transform table size
    localparam int COORD_BITS  = 12;
    localparam int TABLE_WORDS = 18;
    localparam int AXES        = 3;
    localparam int SLOT_OFFSET = 9;
    localparam int SLOT_ROI    = 12;

    // Port and register field widths
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = 5;
    localparam int WORD_W    = 32;
    localparam int FOCAL_W   = 32;
    localparam int CENTER_W  = 28;
    localparam int BASE_W    = 20;
    localparam int STRIDE_W  = 5;
    localparam int DEPTH_W   = 26;
    localparam int RAW_W     = 16;
    localparam int DISP_W    = RAW_W - 1;
    localparam int GRAY_W    = 8;

    // Fixed point: Q16.16, disparity carries 4 fraction bits and is scaled by 4096
    localparam int FRAC_W     = 16;
    localparam int DISP_SHIFT = 12;

    // Depth divide: numerator focal*baseline/4096, quotient limited to depth width
    localparam int NZ_W = FOCAL_W + BASE_W - DISP_SHIFT;
    localparam int ZQ_W = DEPTH_W;

    // Back-projection: ((u << 16) - center) * z, then divide by focal
    localparam int PIX_W  = (COORD_BITS + FRAC_W > CENTER_W) ? COORD_BITS + FRAC_W : CENTER_W;
    localparam int DIFF_W = PIX_W + 1;
    localparam int PROD_W = DIFF_W + ZQ_W + 1;
    localparam int NUM_W  = PIX_W + ZQ_W;
    localparam int XQ_W   = WORD_W - 1;

    // Matrix stage
    localparam int MAC_W = 2 * WORD_W;
    localparam int SUM_W = MAC_W + 2;
    localparam int G_W   = SUM_W - FRAC_W + 1;

    localparam logic signed [RAW_W-1:0]  DISP_MIN      = RAW_W'(8);
    localparam logic signed [WORD_W-1:0] Q_MAX         = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] Q_MIN         = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [DEPTH_W-1:0]       DEPTH_MAX_RST = DEPTH_W'(65536000);
    localparam logic [STRIDE_W-1:0]      STRIDE_RST    = STRIDE_W'(1);

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_TABLE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_CENTER_X  = 3'd2,
        CFG_CENTER_Y  = 3'd3,
        CFG_BASELINE  = 3'd4,
        CFG_STRIDE    = 3'd5,
        CFG_DEPTH_MIN = 3'd6,
        CFG_DEPTH_MAX = 3'd7
    } cfg_reg_t;

endpackage

### src/dtgp_div.sv
// ============================================================================
// dtgp_div: pipelined unsigned divider, one quotient bit per stage
// Divides a NUM_W-bit magnitude by a 32-bit divisor into a 31-bit quotient
// and flags quotients that do not fit (caller saturates).
// ============================================================================
module dtgp_div
    import dtgp_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [WORD_W-1:0] den,
    output logic [XQ_W-1:0]   quo,
    output logic              ovf
);

    typedef struct packed {
        logic              ovf;
        logic [WORD_W-1:0] rem;
        logic [XQ_W-1:0]   q;
    } dstage_t;

    dstage_t st_reg [XQ_W];

    for (genvar k = 0; k < XQ_W; k++) begin : g_st
        dstage_t         src;
        dstage_t         dst;
        logic [WORD_W:0] t;
        logic            ge;

        // First stage loads the high numerator bits as partial remainder
        if (k == 0) begin : g_first
            always_comb
            begin
                src.rem = WORD_W'(num[NUM_W-1:XQ_W]);
                src.q   = num[XQ_W-1:0];
                src.ovf = (WORD_W'(num[NUM_W-1:XQ_W]) >= den);
            end
        end else begin : g_next
            assign src = st_reg[k-1];
        end

        // Restoring step: shift in next numerator bit, subtract if it fits
        always_comb
        begin
            t       = {src.rem, src.q[XQ_W-1]};
            ge      = (t >= {1'b0, den});
            dst.ovf = src.ovf;
            dst.rem = ge ? WORD_W'(t - {1'b0, den}) : t[WORD_W-1:0];
            dst.q   = {src.q[XQ_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= dst;
            end
        end
    end

    assign quo = st_reg[XQ_W-1].q;
    assign ovf = st_reg[XQ_W-1].ovf;

endmodule

### src/disparity_to_gravity_point.sv
// ============================================================================
// disparity_to_gravity_point: stereo disparity pixel to gravity-frame point
// Filters pixels, computes depth, back-projects, applies the 3x3 transform
// plus offset and the ROI test, and emits accepted points.
// ============================================================================
// Usage:
//   pix channel (pix_valid/pix_stall): command 0 carries a pixel, command 1
//   writes one transform/ROI table word (word_index, word_value). Beats are
//   taken whenever pix_valid is high and pix_stall is low.
//   pt channel (pt_valid/pt_stall): one beat per accepted point, nothing for
//   filtered pixels or table writes.
//   cfg channel (cfg_valid/cfg_ready): always ready; the user must write
//   registers only while no pixel is in flight, and this is left to the user to enforce.
// Pipeline length: set mostly by the two bit-per-stage dividers (26 stages
//   for depth, 31 for the x/y quotient).
// Throughput: one beat per cycle while pix_stall is low. Table writes take
//   effect in order with pixels, at the transform stage.
// Stall: the pipeline keeps moving while its last stage is empty; it freezes,
//   and pix_stall rises, only when a finished point waits behind a stalled
//   output register.
// Reset: clears all valid bits and config registers (stride 1, depth max
//   1000 m). The table is undefined until written.
// ============================================================================
module disparity_to_gravity_point
    import dtgp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     pix_valid,
    output logic                     pix_stall,
    input  logic                     command,
    input  logic [COORD_BITS-1:0]    pixel_col,
    input  logic [COORD_BITS-1:0]    pixel_row,
    input  logic signed [RAW_W-1:0]  disparity_raw,
    input  logic [GRAY_W-1:0]        gray_level,
    input  logic [IDX_W-1:0]         word_index,
    input  logic signed [WORD_W-1:0] word_value,

    output logic                     pt_valid,
    input  logic                     pt_stall,
    output logic signed [WORD_W-1:0] point_x,
    output logic signed [WORD_W-1:0] point_y,
    output logic signed [WORD_W-1:0] point_z,
    output logic [GRAY_W-1:0]        point_gray,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Local stage types
    // ------------------------------------------------------------------
    typedef struct packed {
        cmd_t                  cmd;
        logic [COORD_BITS-1:0] u;
        logic [COORD_BITS-1:0] v;
        logic [DISP_W-1:0]     raw;
        logic [GRAY_W-1:0]     gray;
        logic [IDX_W-1:0]      idx;
        logic [WORD_W-1:0]     wval;
    } item_t;

    typedef struct packed {
        item_t                 it;
        logic [DISP_W-1:0]     rem;
        logic [ZQ_W-1:0]       zq;
        logic [STRIDE_W-1:0]   ru;
        logic [STRIDE_W-1:0]   rv;
        logic [COORD_BITS-1:0] us;
        logic [COORD_BITS-1:0] vs;
    } zd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [GRAY_W-1:0]        gray;
        logic [IDX_W-1:0]         idx;
        logic [WORD_W-1:0]        wval;
        logic [ZQ_W-1:0]          z;
        logic signed [PROD_W-1:0] nx;
        logic signed [PROD_W-1:0] ny;
    } sm_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [GRAY_W-1:0] gray;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] wval;
        logic [ZQ_W-1:0]   z;
        logic              negx;
        logic              negy;
    } xd_t;

    typedef struct packed {
        xd_t              side;
        logic [NUM_W-1:0] magx;
        logic [NUM_W-1:0] magy;
    } sa_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [GRAY_W-1:0]        gray;
        logic [IDX_W-1:0]         idx;
        logic [WORD_W-1:0]        wval;
        logic [ZQ_W-1:0]          z;
        logic signed [WORD_W-1:0] xr;
        logic signed [WORD_W-1:0] yr;
    } sx_t;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [FOCAL_W-1:0]  focal_x_reg;
    logic [FOCAL_W-1:0]  focal_y_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [BASE_W-1:0]   baseline_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [DEPTH_W-1:0]  depth_min_reg;
    logic [DEPTH_W-1:0]  depth_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg   <= '0;
            focal_y_reg   <= '0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            baseline_reg  <= '0;
            stride_reg    <= STRIDE_RST;
            depth_min_reg <= '0;
            depth_max_reg <= DEPTH_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FOCAL_X:   focal_x_reg   <= cfg_data[FOCAL_W-1:0];
                CFG_FOCAL_Y:   focal_y_reg   <= cfg_data[FOCAL_W-1:0];
                CFG_CENTER_X:  center_x_reg  <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:  center_y_reg  <= cfg_data[CENTER_W-1:0];
                CFG_BASELINE:  baseline_reg  <= cfg_data[BASE_W-1:0];
                CFG_STRIDE:    stride_reg    <= cfg_data[STRIDE_W-1:0];
                CFG_DEPTH_MIN: depth_min_reg <= cfg_data[DEPTH_W-1:0];
                CFG_DEPTH_MAX: depth_max_reg <= cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    logic                cfg_live;
    logic [STRIDE_W-1:0] stride_eff;

    assign cfg_live   = (focal_x_reg != '0) && (focal_y_reg != '0) && (baseline_reg != '0);
    assign stride_eff = (stride_reg == '0) ? STRIDE_RST : stride_reg;

    // ------------------------------------------------------------------
    // Global advance: freeze only when a finished point cannot leave
    // ------------------------------------------------------------------
    logic adv;
    logic out_free;
    logic sr_valid_reg;
    logic pt_valid_reg;

    assign out_free  = !pt_valid_reg || !pt_stall;
    assign adv       = out_free || !sr_valid_reg;
    assign pix_stall = !adv;

    // ------------------------------------------------------------------
    // Stage s1: capture beat, early pixel filter
    // ------------------------------------------------------------------
    item_t s1_reg;
    item_t s1_next;
    logic  s1_valid_reg;
    logic  s1_keep;

    always_comb
    begin
        s1_next.cmd  = cmd_t'(command);
        s1_next.u    = pixel_col;
        s1_next.v    = pixel_row;
        s1_next.raw  = disparity_raw[DISP_W-1:0];
        s1_next.gray = gray_level;
        s1_next.idx  = word_index;
        s1_next.wval = word_value;
        s1_keep      = (cmd_t'(command) == CMD_TABLE)
                    || (cfg_live && (disparity_raw > DISP_MIN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= pix_valid && s1_keep;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_reg <= s1_next;
    end

    // ------------------------------------------------------------------
    // Stage s2: focal * baseline / 4096
    // ------------------------------------------------------------------
    logic [FOCAL_W+BASE_W-1:0] fb_prod;
    item_t                     s2_reg;
    logic [NZ_W-1:0]           s2_n_reg;
    logic                      s2_valid_reg;

    assign fb_prod = focal_x_reg * baseline_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg   <= s1_reg;
            s2_n_reg <= fb_prod[FOCAL_W+BASE_W-1:DISP_SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // Depth divide, one bit per stage; grid remainders ride along
    // ------------------------------------------------------------------
    zd_t  zd_reg       [ZQ_W];
    logic zd_valid_reg [ZQ_W];

    for (genvar k = 0; k < ZQ_W; k++) begin : g_zd
        zd_t               src;
        zd_t               dst;
        logic              src_valid;
        logic [DISP_W:0]   zt;
        logic [STRIDE_W:0] ut;
        logic [STRIDE_W:0] vt;

        if (k == 0) begin : g_first
            logic zovf;
            // Quotient too wide for the depth range: pixel is dropped
            always_comb
            begin
                zovf      = (DISP_W'(s2_n_reg[NZ_W-1:ZQ_W]) >= s2_reg.raw);
                src.it    = s2_reg;
                src.rem   = DISP_W'(s2_n_reg[NZ_W-1:ZQ_W]);
                src.zq    = s2_n_reg[ZQ_W-1:0];
                src.ru    = '0;
                src.rv    = '0;
                src.us    = s2_reg.u;
                src.vs    = s2_reg.v;
                src_valid = s2_valid_reg && !(s2_reg.cmd == CMD_PIXEL && zovf);
            end
        end else begin : g_next
            assign src       = zd_reg[k-1];
            assign src_valid = zd_valid_reg[k-1];
        end

        always_comb
        begin
            dst = src;
            // depth quotient bit
            zt = {src.rem, src.zq[ZQ_W-1]};
            if (zt >= {1'b0, src.it.raw})
            begin
                dst.rem = DISP_W'(zt - {1'b0, src.it.raw});
                dst.zq  = {src.zq[ZQ_W-2:0], 1'b1};
            end
            else
            begin
                dst.rem = zt[DISP_W-1:0];
                dst.zq  = {src.zq[ZQ_W-2:0], 1'b0};
            end
            // grid remainder bit for column and row
            ut = {src.ru, src.us[COORD_BITS-1]};
            vt = {src.rv, src.vs[COORD_BITS-1]};
            if (k < COORD_BITS)
            begin
                dst.ru = (ut >= {1'b0, stride_eff}) ? STRIDE_W'(ut - {1'b0, stride_eff})
                                                    : ut[STRIDE_W-1:0];
                dst.rv = (vt >= {1'b0, stride_eff}) ? STRIDE_W'(vt - {1'b0, stride_eff})
                                                    : vt[STRIDE_W-1:0];
                dst.us = {src.us[COORD_BITS-2:0], 1'b0};
                dst.vs = {src.vs[COORD_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                zd_valid_reg[k] <= 1'b0;
            else if (adv)
                zd_valid_reg[k] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                zd_reg[k] <= dst;
        end
    end

    // ------------------------------------------------------------------
    // Stage sm: grid and depth range check, back-projection numerators
    // ------------------------------------------------------------------
    zd_t                      zl;
    logic [ZQ_W-1:0]          zl_z;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [ZQ_W:0]     zs;
    logic                     sm_keep;
    sm_t                      sm_next;
    sm_t                      sm_reg;
    logic                     sm_valid_reg;

    assign zl   = zd_reg[ZQ_W-1];
    assign zl_z = zl.zq;

    always_comb
    begin
        dx = signed'(DIFF_W'({zl.it.u, {FRAC_W{1'b0}}})) - signed'(DIFF_W'(center_x_reg));
        dy = signed'(DIFF_W'({zl.it.v, {FRAC_W{1'b0}}})) - signed'(DIFF_W'(center_y_reg));
        zs = signed'({1'b0, zl_z});
        sm_keep = (zl.it.cmd == CMD_TABLE)
               || ((zl.ru == '0) && (zl.rv == '0)
                   && (zl_z >= depth_min_reg) && (zl_z <= depth_max_reg));
        sm_next.cmd  = zl.it.cmd;
        sm_next.gray = zl.it.gray;
        sm_next.idx  = zl.it.idx;
        sm_next.wval = zl.it.wval;
        sm_next.z    = zl_z;
        sm_next.nx   = dx * zs;
        sm_next.ny   = dy * zs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_valid_reg <= 1'b0;
        else if (adv)
            sm_valid_reg <= zd_valid_reg[ZQ_W-1] && sm_keep;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sm_reg <= sm_next;
    end

    // ------------------------------------------------------------------
    // Stage sa: sign and magnitude for the focal divide
    // ------------------------------------------------------------------
    sa_t  sa_next;
    sa_t  sa_reg;
    logic sa_valid_reg;

    always_comb
    begin
        sa_next.side.cmd  = sm_reg.cmd;
        sa_next.side.gray = sm_reg.gray;
        sa_next.side.idx  = sm_reg.idx;
        sa_next.side.wval = sm_reg.wval;
        sa_next.side.z    = sm_reg.z;
        sa_next.side.negx = sm_reg.nx[PROD_W-1];
        sa_next.side.negy = sm_reg.ny[PROD_W-1];
        sa_next.magx      = NUM_W'(sm_reg.nx[PROD_W-1] ? -sm_reg.nx : sm_reg.nx);
        sa_next.magy      = NUM_W'(sm_reg.ny[PROD_W-1] ? -sm_reg.ny : sm_reg.ny);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_valid_reg <= 1'b0;
        else if (adv)
            sa_valid_reg <= sm_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sa_reg <= sa_next;
    end

    // ------------------------------------------------------------------
    // Focal dividers, side fields delayed to match
    // ------------------------------------------------------------------
    logic [XQ_W-1:0] qx;
    logic [XQ_W-1:0] qy;
    logic            ovfx;
    logic            ovfy;

    dtgp_div u_div_x (
        .clk (clk),
        .en  (adv),
        .num (sa_reg.magx),
        .den (focal_x_reg),
        .quo (qx),
        .ovf (ovfx)
    );

    dtgp_div u_div_y (
        .clk (clk),
        .en  (adv),
        .num (sa_reg.magy),
        .den (focal_y_reg),
        .quo (qy),
        .ovf (ovfy)
    );

    xd_t  xd_reg       [XQ_W];
    logic xd_valid_reg [XQ_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < XQ_W; i++)
                xd_valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            xd_valid_reg[0] <= sa_valid_reg;
            for (int i = 1; i < XQ_W; i++)
                xd_valid_reg[i] <= xd_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xd_reg[0] <= sa_reg.side;
            for (int i = 1; i < XQ_W; i++)
                xd_reg[i] <= xd_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage sx: signed, saturated camera x and y
    // ------------------------------------------------------------------
    function automatic logic signed [WORD_W-1:0] clamp_quo(
        input logic [XQ_W-1:0] q,
        input logic            neg,
        input logic            ovf
    );
        logic signed [WORD_W-1:0] mag;
        begin
            mag = signed'(WORD_W'(q));
            if (ovf)
                return neg ? Q_MIN : Q_MAX;
            return neg ? -mag : mag;
        end
    endfunction

    xd_t  xl;
    sx_t  sx_next;
    sx_t  sx_reg;
    logic sx_valid_reg;

    assign xl = xd_reg[XQ_W-1];

    always_comb
    begin
        sx_next.cmd  = xl.cmd;
        sx_next.gray = xl.gray;
        sx_next.idx  = xl.idx;
        sx_next.wval = xl.wval;
        sx_next.z    = xl.z;
        sx_next.xr   = clamp_quo(qx, xl.negx, ovfx);
        sx_next.yr   = clamp_quo(qy, xl.negy, ovfy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sx_valid_reg <= 1'b0;
        else if (adv)
            sx_valid_reg <= xd_valid_reg[XQ_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sx_reg <= sx_next;
    end

    // ------------------------------------------------------------------
    // Transform table: written and read from stage sx, so order holds
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] tab_reg [TABLE_WORDS];
    logic                     tab_we;

    assign tab_we = adv && sx_valid_reg && (sx_reg.cmd == CMD_TABLE)
                 && (sx_reg.idx < IDX_W'(TABLE_WORDS));

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_reg[sx_reg.idx] <= sx_reg.wval;
    end

    // ------------------------------------------------------------------
    // Stage sw: nine matrix products, snapshot of offset and ROI
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] coord       [AXES];
    logic signed [MAC_W-1:0]  sw_prod_reg [AXES*AXES];
    logic signed [WORD_W-1:0] sw_off_reg  [AXES];
    logic signed [WORD_W-1:0] sw_roi_reg  [2*AXES];
    logic [GRAY_W-1:0]        sw_gray_reg;
    logic                     sw_valid_reg;

    assign coord[0] = sx_reg.xr;
    assign coord[1] = sx_reg.yr;
    assign coord[2] = signed'(WORD_W'(sx_reg.z));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sw_valid_reg <= 1'b0;
        else if (adv)
            sw_valid_reg <= sx_valid_reg && (sx_reg.cmd == CMD_PIXEL);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < AXES; r++)
            begin
                for (int k = 0; k < AXES; k++)
                    sw_prod_reg[r*AXES+k] <= tab_reg[r*AXES+k] * coord[k];
                sw_off_reg[r] <= tab_reg[SLOT_OFFSET+r];
            end
            for (int j = 0; j < 2*AXES; j++)
                sw_roi_reg[j] <= tab_reg[SLOT_ROI+j];
            sw_gray_reg <= sx_reg.gray;
        end
    end

    // ------------------------------------------------------------------
    // Stage ss: row sums
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  ss_sum_reg [AXES];
    logic signed [WORD_W-1:0] ss_off_reg [AXES];
    logic signed [WORD_W-1:0] ss_roi_reg [2*AXES];
    logic [GRAY_W-1:0]        ss_gray_reg;
    logic                     ss_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ss_valid_reg <= 1'b0;
        else if (adv)
            ss_valid_reg <= sw_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < AXES; r++)
            begin
                ss_sum_reg[r] <= SUM_W'(sw_prod_reg[r*AXES]) + SUM_W'(sw_prod_reg[r*AXES+1])
                               + SUM_W'(sw_prod_reg[r*AXES+2]);
                ss_off_reg[r] <= sw_off_reg[r];
            end
            for (int j = 0; j < 2*AXES; j++)
                ss_roi_reg[j] <= sw_roi_reg[j];
            ss_gray_reg <= sw_gray_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage so: floor to Q16.16, add offset, saturate
    // ------------------------------------------------------------------
    logic signed [G_W-1:0]    gw     [AXES];
    logic signed [WORD_W-1:0] g_sat  [AXES];
    logic signed [WORD_W-1:0] so_g_reg   [AXES];
    logic signed [WORD_W-1:0] so_roi_reg [2*AXES];
    logic [GRAY_W-1:0]        so_gray_reg;
    logic                     so_valid_reg;

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            gw[r] = G_W'(ss_sum_reg[r] >>> FRAC_W) + G_W'(ss_off_reg[r]);
            if (gw[r] > G_W'(Q_MAX))
                g_sat[r] = Q_MAX;
            else if (gw[r] < G_W'(Q_MIN))
                g_sat[r] = Q_MIN;
            else
                g_sat[r] = WORD_W'(gw[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            so_valid_reg <= 1'b0;
        else if (adv)
            so_valid_reg <= ss_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < AXES; r++)
                so_g_reg[r] <= g_sat[r];
            for (int j = 0; j < 2*AXES; j++)
                so_roi_reg[j] <= ss_roi_reg[j];
            so_gray_reg <= ss_gray_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage sr: inclusive ROI box test
    // ------------------------------------------------------------------
    logic                     roi_pass;
    logic signed [WORD_W-1:0] sr_g_reg [AXES];
    logic [GRAY_W-1:0]        sr_gray_reg;

    always_comb
    begin
        roi_pass = 1'b1;
        for (int r = 0; r < AXES; r++)
        begin
            if ((so_g_reg[r] < so_roi_reg[2*r]) || (so_g_reg[r] > so_roi_reg[2*r+1]))
                roi_pass = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sr_valid_reg <= 1'b0;
        else if (adv)
            sr_valid_reg <= so_valid_reg && roi_pass;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < AXES; r++)
                sr_g_reg[r] <= so_g_reg[r];
            sr_gray_reg <= so_gray_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] px_reg;
    logic signed [WORD_W-1:0] py_reg;
    logic signed [WORD_W-1:0] pz_reg;
    logic [GRAY_W-1:0]        pg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pt_valid_reg <= 1'b0;
        else if (out_free)
            pt_valid_reg <= sr_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            px_reg <= sr_g_reg[0];
            py_reg <= sr_g_reg[1];
            pz_reg <= sr_g_reg[2];
            pg_reg <= sr_gray_reg;
        end
    end

    assign pt_valid   = pt_valid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign point_z    = pz_reg;
    assign point_gray = pg_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (pt_valid && pt_stall && sr_valid_reg))
        else $error("input stalled without a blocked finished point");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(sr_valid_reg) && $stable(sr_gray_reg)))
        else $error("last stage changed while pipeline frozen");

    a_table_beat_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && sx_valid_reg && (sx_reg.cmd == CMD_TABLE)) |=> !sw_valid_reg)
        else $error("table write beat went past the transform stage");

endmodule

### dv/gravity_point_checker.sv
// ----------------------------------------------------------------------------
// gravity_point_checker: point prediction and compare for the disparity block
// Watches the config, pixel and point channels. Each accepted pixel beat is
// run through a fixed-point model of the pipeline, and each accepted point
// beat is compared field by field with the oldest predicted point.
// ----------------------------------------------------------------------------
module gravity_point_checker
    import dtgp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pix_valid,
    input  logic                     pix_stall,
    input  logic                     command,
    input  logic [COORD_BITS-1:0]    pixel_col,
    input  logic [COORD_BITS-1:0]    pixel_row,
    input  logic signed [RAW_W-1:0]  disparity_raw,
    input  logic [GRAY_W-1:0]        gray_level,
    input  logic [IDX_W-1:0]         word_index,
    input  logic signed [WORD_W-1:0] word_value,
    input  logic                     pt_valid,
    input  logic                     pt_stall,
    input  logic signed [WORD_W-1:0] point_x,
    input  logic signed [WORD_W-1:0] point_y,
    input  logic signed [WORD_W-1:0] point_z,
    input  logic [GRAY_W-1:0]        point_gray,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    output int                       fail_count,
    output int                       points_pending
);

    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] z;
        logic [GRAY_W-1:0]        gray;
    } point_t;

    // Shadow copy of the block's registers and table
    logic [FOCAL_W-1:0]       fx, fy;
    logic [CENTER_W-1:0]      cx, cy;
    logic [BASE_W-1:0]        base;
    logic [STRIDE_W-1:0]      stride;
    logic [DEPTH_W-1:0]       dmin, dmax;
    logic signed [WORD_W-1:0] xform [TABLE_WORDS];

    point_t expected_points [$];

    assign points_pending = expected_points.size();

    function automatic logic signed [WORD_W-1:0] clamp32(input logic signed [66:0] v);
        if (v > 67'sd2147483647)
            return Q_MAX;
        if (v < -67'sd2147483648)
            return Q_MIN;
        return v[WORD_W-1:0];
    endfunction

    // One row of the matrix: floor(sum of products / 2^16) plus offset
    function automatic logic signed [WORD_W-1:0] apply_row(input int r, input longint px,
                                                           input longint py, input longint pz);
        logic signed [66:0] acc;
        acc = 67'(longint'(xform[r*AXES]) * px);
        acc = acc + 67'(longint'(xform[r*AXES+1]) * py);
        acc = acc + 67'(longint'(xform[r*AXES+2]) * pz);
        acc = (acc >>> FRAC_W) + 67'(xform[SLOT_OFFSET+r]);
        return clamp32(acc);
    endfunction

    // Full pixel path; returns 1 when a point comes out
    function automatic bit project_pixel(input logic [COORD_BITS-1:0] u,
                                         input logic [COORD_BITS-1:0] v,
                                         input logic signed [RAW_W-1:0] raw,
                                         input logic [GRAY_W-1:0] gray,
                                         output point_t p);
        logic [63:0] num;
        logic [63:0] den;
        longint      z;
        longint      xr;
        longint      yr;
        int          step;
        p = '0;
        if (fx == 0 || fy == 0 || base == 0)
            return 0;
        step = (stride == 0) ? 1 : int'(stride);
        if ((int'(u) % step) != 0 || (int'(v) % step) != 0)
            return 0;
        if (raw <= DISP_MIN)
            return 0;
        num = 64'(fx) * 64'(base);
        den = 64'(raw[RAW_W-2:0]) << DISP_SHIFT;
        z   = longint'(num / den);
        if (z < longint'(dmin) || z > longint'(dmax))
            return 0;
        xr = ((longint'(u) <<< FRAC_W) - longint'(cx)) * z / longint'(fx);
        yr = ((longint'(v) <<< FRAC_W) - longint'(cy)) * z / longint'(fy);
        xr = longint'(clamp32(67'(xr)));
        yr = longint'(clamp32(67'(yr)));
        p.x    = apply_row(0, xr, yr, z);
        p.y    = apply_row(1, xr, yr, z);
        p.z    = apply_row(2, xr, yr, z);
        p.gray = gray;
        if (p.x < xform[SLOT_ROI]   || p.x > xform[SLOT_ROI+1] ||
            p.y < xform[SLOT_ROI+2] || p.y > xform[SLOT_ROI+3] ||
            p.z < xform[SLOT_ROI+4] || p.z > xform[SLOT_ROI+5])
            return 0;
        return 1;
    endfunction

    // Channel monitor: config, pixel beats, point beats
    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        point_t got;
        if (!rst_n)
        begin
            fx <= '0; fy <= '0; cx <= '0; cy <= '0; base <= '0;
            stride <= STRIDE_RST; dmin <= '0; dmax <= DEPTH_MAX_RST;
            fail_count <= 0;
            expected_points.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_FOCAL_X:   fx     <= cfg_data;
                    CFG_FOCAL_Y:   fy     <= cfg_data;
                    CFG_CENTER_X:  cx     <= cfg_data[CENTER_W-1:0];
                    CFG_CENTER_Y:  cy     <= cfg_data[CENTER_W-1:0];
                    CFG_BASELINE:  base   <= cfg_data[BASE_W-1:0];
                    CFG_STRIDE:    stride <= cfg_data[STRIDE_W-1:0];
                    CFG_DEPTH_MIN: dmin   <= cfg_data[DEPTH_W-1:0];
                    CFG_DEPTH_MAX: dmax   <= cfg_data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            // compare outgoing point against oldest prediction
            if (pt_valid && !pt_stall)
            begin
                got = '{point_x, point_y, point_z, point_gray};
                if (expected_points.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected point x=%0d y=%0d z=%0d gray=%0d",
                                 got.x, got.y, got.z, got.gray);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got != want)
                    begin
                        if (fail_count < 10)
                            $display({"point mismatch exp x=%0d y=%0d z=%0d gray=%0d",
                                      " got x=%0d y=%0d z=%0d gray=%0d"},
                                     want.x, want.y, want.z, want.gray,
                                     got.x, got.y, got.z, got.gray);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // incoming beat: table write or pixel
            if (pix_valid && !pix_stall)
            begin
                if (cmd_t'(command) == CMD_TABLE)
                begin
                    if (word_index < TABLE_WORDS)
                        xform[word_index] = word_value;
                end
                else if (project_pixel(pixel_col, pixel_row, disparity_raw, gray_level, want))
                    expected_points = {expected_points, want};
            end
        end
    end

endmodule

### dv/disparity_to_gravity_point_tb.sv
// ----------------------------------------------------------------------------
// disparity_to_gravity_point_tb: stimulus and verdict for the disparity block
// Loads the transform table, walks through several camera/depth settings,
// and sends directed and random pixel and table beats under varied idling
// and back-pressure. Checking is done in gravity_point_checker.
// ----------------------------------------------------------------------------
module disparity_to_gravity_point_tb;
    import dtgp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 400;

    logic                     clk;
    logic                     rst_n;
    logic                     pix_valid;
    logic                     pix_stall;
    logic                     command;
    logic [COORD_BITS-1:0]    pixel_col;
    logic [COORD_BITS-1:0]    pixel_row;
    logic signed [RAW_W-1:0]  disparity_raw;
    logic [GRAY_W-1:0]        gray_level;
    logic [IDX_W-1:0]         word_index;
    logic signed [WORD_W-1:0] word_value;
    logic                     pt_valid;
    logic                     pt_stall;
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic signed [WORD_W-1:0] point_z;
    logic [GRAY_W-1:0]        point_gray;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [WORD_W-1:0]        cfg_data;

    int  fail_count;
    int  points_pending;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cycle_count;
    int  hold_left;
    bit  hold_go;
    bit  hold_done;
    int  cur_stride;

    typedef struct {
        logic [31:0] fx, fy, cx, cy, base, stride, dmin, dmax;
        int          items;
    } camera_setting_t;

    camera_setting_t settings [6];

    disparity_to_gravity_point u_dut (.*);

    gravity_point_checker u_checker (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Output back-pressure with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            pt_stall  <= 1'b1;
            hold_left <= hold_left + 1;
            if (hold_left == HOLD_CYCLES)
                hold_done <= 1'b1;
        end
        else
            pt_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // One beat on the pixel channel, with idle cycles drawn per cycle in front
    task automatic send_beat(input cmd_t cmd, input logic [COORD_BITS-1:0] u,
                             input logic [COORD_BITS-1:0] v, input logic [RAW_W-1:0] raw,
                             input logic [GRAY_W-1:0] gray, input logic [IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid     <= 1'b1;
        command       <= cmd;
        pixel_col     <= u;
        pixel_row     <= v;
        disparity_raw <= raw;
        gray_level    <= gray;
        word_index    <= idx;
        word_value    <= val;
        do @(posedge clk); while (pix_stall);
    endtask

    task automatic write_table(input int idx, input logic [WORD_W-1:0] val);
        send_beat(CMD_TABLE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  RAW_W'($urandom), GRAY_W'($urandom), IDX_W'(idx), val);
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] u, input logic [COORD_BITS-1:0] v,
                              input logic [RAW_W-1:0] raw, input logic [GRAY_W-1:0] gray);
        send_beat(CMD_PIXEL, u, v, raw, gray, IDX_W'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (points_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_setting(input camera_setting_t s);
        write_reg(CFG_FOCAL_X, s.fx);
        write_reg(CFG_FOCAL_Y, s.fy);
        write_reg(CFG_CENTER_X, s.cx);
        write_reg(CFG_CENTER_Y, s.cy);
        write_reg(CFG_BASELINE, s.base);
        write_reg(CFG_STRIDE, s.stride);
        write_reg(CFG_DEPTH_MIN, s.dmin);
        write_reg(CFG_DEPTH_MAX, s.dmax);
        cfg_valid  <= 1'b0;
        cur_stride = (s.stride == 0) ? 1 : int'(s.stride);
    endtask

    // Random table word: small matrix entries, wide ROI, full-range otherwise
    task automatic random_table_write();
        int          idx;
        logic [31:0] val;
        idx = $urandom_range(31);
        val = $urandom;
        if (idx < SLOT_OFFSET && $urandom_range(3) != 0)
            val = 32'($signed($urandom_range(262144)) - 131072);
        else if (idx >= SLOT_OFFSET && idx < SLOT_ROI && $urandom_range(1) == 0)
            val = 32'($signed($urandom_range(2000000)) - 1000000);
        else if (idx >= SLOT_ROI && idx < TABLE_WORDS)
            val = ((idx - SLOT_ROI) % 2 == 0) ? {1'b1, val[30:0]} : {1'b0, val[30:0]};
        write_table(idx, val);
    endtask

    task automatic random_pixel();
        logic [RAW_W-1:0] raw;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 70)
            raw = RAW_W'($urandom_range(32767, 9));
        else if (pick < 85)
            raw = RAW_W'($urandom_range(400, 9));
        else
            raw = RAW_W'($urandom);
        if ($urandom_range(9) < 8)
            send_pixel(COORD_BITS'($urandom_range(4095 / cur_stride) * cur_stride),
                       COORD_BITS'($urandom_range(4095 / cur_stride) * cur_stride),
                       raw, GRAY_W'($urandom));
        else
            send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom), raw,
                       GRAY_W'($urandom));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        pix_valid      = 1'b0;
        command        = CMD_PIXEL;
        pixel_col      = '0;
        pixel_row      = '0;
        disparity_raw  = '0;
        gray_level     = '0;
        word_index     = '0;
        word_value     = '0;
        pt_stall       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_FOCAL_X;
        cfg_data       = '0;
        cycle_count    = 0;
        hold_go        = 1'b0;
        hold_done      = 1'b0;
        hold_left      = 0;
        cur_stride     = 1;
        send_idle_pct  = 32;
        recv_stall_pct = 57;

        settings[0] = '{32'd500 << 16, 32'd500 << 16, 32'd320 << 16, 32'd240 << 16,
                        32'd6554, 32'd1, 32'd0, 32'd65536000, 240};
        settings[1] = '{32'hFFFF_FFFF, 32'd1 << 16, 32'd268435455, 32'd0,
                        32'd655359, 32'd16, 32'd0, 32'd65536000, 240};
        settings[2] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd268435455,
                        32'd1, 32'd3, 32'd0, 32'd0, 240};
        settings[3] = '{32'd700 << 16, 32'd0, 32'd100 << 16, 32'd100 << 16,
                        32'd0, 32'd1, 32'd0, 32'd65536000, 60};
        settings[4] = '{32'd1000 << 16, 32'd1000 << 16, 32'd2048 << 16, 32'd0,
                        32'd65536, 32'd2, 32'd5 << 16, 32'd200 << 16, 240};
        settings[5] = '{32'd350 << 16, 32'd350 << 16, 32'd640 << 16, 32'd480 << 16,
                        32'd655359, 32'd5, 32'd0, 32'd65536000, 240};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the table: identity matrix, offset, full-range ROI
        for (int i = 0; i < TABLE_WORDS; i++)
        begin
            if (i < SLOT_OFFSET)
                write_table(i, (i % 4 == 0) ? 32'h0001_0000 : 32'h0);
            else if (i < SLOT_ROI)
                write_table(i, 32'h0002_8000);
            else
                write_table(i, ((i - SLOT_ROI) % 2 == 0) ? Q_MIN : Q_MAX);
        end
        // Reset focal lengths are zero: nothing may come out
        send_pixel(12'd0, 12'd0, 16'd320, 8'd7);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct  = (ph < 2) ? 32 : (ph < 4) ? 57 : 0;
            recv_stall_pct = (ph < 2) ? 57 : (ph < 4) ? 32 : 0;
            load_setting(settings[ph]);
            if (ph == 0)
            begin
                // Directed: coordinate and disparity extremes, gray extremes
                send_pixel(12'd0, 12'd0, 16'd9, 8'd0);
                send_pixel(12'd4095, 12'd4095, 16'd32767, 8'd255);
                send_pixel(12'd320, 12'd240, 16'd8, 8'd1);
                send_pixel(12'd320, 12'd240, 16'd0, 8'd2);
                send_pixel(12'd100, 12'd4095, 16'h8000, 8'd3);
                send_pixel(12'd4095, 12'd0, 16'hFFFF, 8'd4);
                send_pixel(12'd1, 12'd2, 16'd16, 8'd170);
                write_table(31, 32'hFFFF_FFFF);
                write_table(TABLE_WORDS, 32'h0);
                send_pixel(12'd640, 12'd480, 16'd1024, 8'd85);
            end
            for (int n = 0; n < settings[ph].items; n++)
            begin
                if (ph == 0 && n == 100)
                    hold_go <= 1'b1;
                if (ph == 4 && n == 120)
                begin
                    pix_valid <= 1'b0;
                    while (points_pending != 0) @(posedge clk);
                end
                if ($urandom_range(99) < 5)
                    random_table_write();
                else
                    random_pixel();
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
src/dtgp_pkg.sv
src/dtgp_div.sv
src/disparity_to_gravity_point.sv
dv/gravity_point_checker.sv
dv/disparity_to_gravity_point_tb.sv
